// File: rtl/core/bdpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdpc_pkg;

    localparam int DEBOUNCE_W = 10;
    localparam int COUNT_W    = 16;
    localparam int CLASS_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_THRESHOLD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FACTORY_THRESHOLD = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd50;
    localparam logic [COUNT_W-1:0]    LONG_RESET     = 16'd3000;
    localparam logic [COUNT_W-1:0]    FACTORY_RESET  = 16'd10000;

    // Press classes.
    localparam logic [CLASS_W-1:0] CLASS_SHORT   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_LONG    = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_FACTORY = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_time;
        logic [COUNT_W-1:0]    long_threshold;
        logic [COUNT_W-1:0]    factory_threshold;
    } t_cfg;

    typedef struct packed {
        logic               event_valid;
        logic [CLASS_W-1:0] press_class;
        logic [COUNT_W-1:0] held_ticks;
        logic [CLASS_W-1:0] held_class;
        logic               is_confirmed;
    } t_result;

    // Factory is checked first, so it wins when both thresholds are met.
    function automatic logic [CLASS_W-1:0] classify(input logic [COUNT_W-1:0] ticks,
                                                    input t_cfg cfg);
        logic [CLASS_W-1:0] cls;
        if (ticks >= cfg.factory_threshold) begin
            cls = CLASS_FACTORY;
        end else if (ticks >= cfg.long_threshold) begin
            cls = CLASS_LONG;
        end else begin
            cls = CLASS_SHORT;
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/bdpc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bdpc_in_if;
    logic valid;
    logic ready;
    logic level_pressed;

    modport source (output valid, output level_pressed, input ready);
    modport sink   (input valid, input level_pressed, output ready);
endinterface

interface bdpc_out_if;
    import bdpc_pkg::*;
    logic               valid;
    logic               ready;
    logic               event_valid;
    logic [CLASS_W-1:0] press_class;
    logic [COUNT_W-1:0] held_ticks;
    logic [CLASS_W-1:0] held_class;
    logic               is_confirmed;

    modport source (output valid, output event_valid, output press_class,
                    output held_ticks, output held_class, output is_confirmed,
                    input ready);
    modport sink   (input valid, input event_valid, input press_class,
                    input held_ticks, input held_class, input is_confirmed,
                    output ready);
endinterface

interface bdpc_cfg_if;
    import bdpc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/button_debounce_press_classifier.sv
// Button debounce and press classifier.
//
// Input channel i_in carries one item per millisecond tick: the sampled button
// level, with 1 meaning pressed. Output channel o_out returns exactly one item
// for every input item, in order: the release event with its class, the
// current confirmed hold duration and its class, and the confirmed flag.
// Configuration channel i_cfg writes the debounce time (index 0), the long
// threshold (index 1) and the factory threshold (index 2); it is always ready.
//
// An accepted item is held in an input register, and the state update and
// classification run combinationally from there into the output register. The
// block takes one item per cycle while o_out is not stalled; the sustained rate
// is set by the single state update that each item makes as it moves into the
// output register.
//
// Synchronous reset clears the press state to idle with a zero hold count and
// restores the register defaults of 50, 3000 and 10000. When the receiver
// stalls, the output register holds its item and the input register still
// takes one more item, after which i_in.ready drops until o_out drains.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_press_classifier
    import bdpc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bdpc_in_if.sink     i_in,
    bdpc_cfg_if.sink    i_cfg,
    bdpc_out_if.source  o_out
);

    t_cfg    cfg;
    t_result core_result;

    // Input stage.
    logic    r_in_valid;
    logic    r_in_level;
    // Output stage.
    logic    r_out_valid;
    t_result r_out;

    logic    step;
    logic    in_ready;

    // The input stage moves forward whenever the output register is free or
    // being drained this cycle.
    assign step     = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || step;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    bdpc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    // The press state advances only when an item passes into the output register.
    bdpc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_level  (r_in_level),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_level <= i_in.level_pressed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_valid  = r_out.event_valid;
    assign o_out.press_class  = r_out.press_class;
    assign o_out.held_ticks   = r_out.held_ticks;
    assign o_out.held_class   = r_out.held_class;
    assign o_out.is_confirmed = r_out.is_confirmed;

endmodule

`default_nettype wire

// File: rtl/core/bdpc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module bdpc_cfg_regs
    import bdpc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time     <= DEBOUNCE_RESET;
            r_cfg.long_threshold    <= LONG_RESET;
            r_cfg.factory_threshold <= FACTORY_RESET;
        end else if (i_wr_en) begin
            case (i_wr_index)
                REG_DEBOUNCE_TIME: begin
                    r_cfg.debounce_time <= i_wr_data[DEBOUNCE_W-1:0];
                end
                REG_LONG_THRESHOLD: begin
                    r_cfg.long_threshold <= i_wr_data[COUNT_W-1:0];
                end
                REG_FACTORY_THRESHOLD: begin
                    r_cfg.factory_threshold <= i_wr_data[COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/core/bdpc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module bdpc_core
    import bdpc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  wire logic i_level,
    input  wire t_cfg i_cfg,
    output t_result   o_result
);

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE  = 2'd1;
    localparam logic [1:0] PH_CONFIRMED = 2'd2;

    logic [1:0]         r_phase;
    logic [1:0]         n_phase;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               ev;
    logic [CLASS_W-1:0] ev_class;
    logic               conf;
    logic [COUNT_W-1:0] held;

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        ev       = 1'b0;
        ev_class = CLASS_SHORT;
        case (r_phase)
            PH_CONFIRMED: begin
                if (i_level) begin
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                end else begin
                    ev       = 1'b1;
                    ev_class = classify(r_count, i_cfg);
                    n_phase  = PH_IDLE;
                    n_count  = '0;
                end
            end
            PH_DEBOUNCE: begin
                if (i_level) begin
                    // The count stays below the debounce time here, so it cannot wrap.
                    n_count = r_count + 1'b1;
                    if (n_count >= COUNT_W'(i_cfg.debounce_time)) begin
                        n_phase = PH_CONFIRMED;
                    end
                end else begin
                    n_phase = PH_IDLE;
                    n_count = '0;
                end
            end
            default: begin
                n_count = '0;
                n_phase = i_level ? PH_DEBOUNCE : PH_IDLE;
            end
        endcase
    end

    assign conf = (n_phase == PH_CONFIRMED);
    assign held = conf ? n_count : '0;

    always_comb begin
        o_result.event_valid  = ev;
        o_result.press_class  = ev_class;
        o_result.held_ticks   = held;
        o_result.held_class   = conf ? classify(held, i_cfg) : CLASS_SHORT;
        o_result.is_confirmed = conf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire
